// ===== hw/rtl/tc8pwm_pkg.sv =====
// package for the 8-bit timer/counter with compare match and fast pwm
// holds widths, request/mode/clock-select codes and register indexes
// no dependencies
`default_nettype none

package tc8pwm_pkg;

    localparam int COUNT_WIDTH    = 8;
    localparam int PRESCALE_WIDTH = 10;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 8;

    typedef logic [COUNT_WIDTH-1:0]    count_t;
    typedef logic [PRESCALE_WIDTH-1:0] prescale_t;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_CTC    = 2'd1,
        MODE_PWM    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        CS_STOP     = 3'd0,
        CS_DIV1     = 3'd1,
        CS_DIV8     = 3'd2,
        CS_DIV64    = 3'd3,
        CS_DIV256   = 3'd4,
        CS_DIV1024  = 3'd5,
        CS_EXT_FALL = 3'd6,
        CS_EXT_RISE = 3'd7
    } clk_sel_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_MODE        = 3'd0,
        CFG_CLOCK_SEL   = 3'd1,
        CFG_COMPARE     = 3'd2,
        CFG_OVF_IRQ_EN  = 3'd3,
        CFG_CMP_IRQ_EN  = 3'd4
    } cfg_idx_t;

    localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

`default_nettype wire

// ===== hw/rtl/timer_counter_8bit_pwm_unit.sv =====
// top level of the 8-bit timer/counter: prescaler, compare match, ctc and fast pwm
// depends on tc8pwm_pkg
// path: a transaction waits in the input register, then in the result register
// throughput: one transaction per cycle while out_ready keeps up; the state update is
//   a single short pass (increment, compare, select) between the two registers
// reset: asynchronous active-low rst_n clears config, counter, prescaler,
//   flags, pin history, wave level and both valid bits
`default_nettype none

module timer_counter_8bit_pwm_unit
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [tc8pwm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [tc8pwm_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,

    // request channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            req_type,
    input  wire logic                                  ext_pin,
    input  wire logic [7:0]                            load_value,
    input  wire logic [1:0]                            clear_mask,

    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [7:0]                                 count,
    output logic                                       overflow_flag,
    output logic                                       compare_flag,
    output logic                                       irq,
    output logic                                       pwm_out
);
    import tc8pwm_pkg::*;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [2:0]  clk_sel_reg;
    count_t      compare_reg;
    logic        ovf_irq_en_reg;
    logic        cmp_irq_en_reg;

    // timer state
    prescale_t   prescale_reg;
    prescale_t   prescale_next;
    count_t      counter_reg;
    count_t      counter_next;
    logic        ovf_flag_reg;
    logic        ovf_flag_next;
    logic        cmp_flag_reg;
    logic        cmp_flag_next;
    logic        last_pin_reg;
    logic        last_pin_next;
    logic        wave_reg;
    logic        wave_next;

    // input register stage
    logic        s1_valid_reg;
    logic [1:0]  s1_req_reg;
    logic        s1_pin_reg;
    logic [7:0]  s1_load_reg;
    logic [1:0]  s1_mask_reg;

    // result register stage
    logic        out_valid_reg;
    logic [7:0]  out_count_reg;
    logic        out_ovf_reg;
    logic        out_cmp_reg;
    logic        out_irq_reg;
    logic        out_pwm_reg;

    logic        s2_free;
    logic        s1_fire;
    logic        count_ev;
    logic        match;
    count_t      inc_value;
    count_t      step_value;

    // handshake: the result register frees up when empty or being drained,
    // the input register when empty or moving forward
    assign s2_free  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            clk_sel_reg    <= CS_STOP;
            compare_reg    <= '0;
            ovf_irq_en_reg <= 1'b0;
            cmp_irq_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_wdata[1:0];
                CFG_CLOCK_SEL:  clk_sel_reg    <= cfg_wdata[2:0];
                CFG_COMPARE:    compare_reg    <= COUNT_WIDTH'(cfg_wdata);
                CFG_OVF_IRQ_EN: ovf_irq_en_reg <= cfg_wdata[0];
                CFG_CMP_IRQ_EN: cmp_irq_en_reg <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // count source: prescaler taps look at the value before its increment
    always_comb
    begin
        case (clk_sel_reg)
            CS_DIV1:     count_ev = 1'b1;
            CS_DIV8:     count_ev = &prescale_reg[2:0];
            CS_DIV64:    count_ev = &prescale_reg[5:0];
            CS_DIV256:   count_ev = &prescale_reg[7:0];
            CS_DIV1024:  count_ev = &prescale_reg[9:0];
            CS_EXT_FALL: count_ev = last_pin_reg && !s1_pin_reg;
            CS_EXT_RISE: count_ev = !last_pin_reg && s1_pin_reg;
            default:     count_ev = 1'b0;
        endcase
    end

    // counter step for one count event
    assign match      = (counter_reg == compare_reg);
    assign inc_value  = counter_reg + count_t'(1);
    assign step_value = (mode_reg == MODE_CTC && match) ? '0 : inc_value;

    // next state for the transaction in the input register
    always_comb
    begin
        prescale_next = prescale_reg;
        counter_next  = counter_reg;
        ovf_flag_next = ovf_flag_reg;
        cmp_flag_next = cmp_flag_reg;
        last_pin_next = last_pin_reg;
        wave_next     = wave_reg;
        case (s1_req_reg)
            REQ_TICK:
            begin
                prescale_next = prescale_reg + prescale_t'(1);
                last_pin_next = s1_pin_reg;
                if (count_ev)
                begin
                    // compare match first, then overflow: overflow wins the wave level
                    if (match)
                    begin
                        cmp_flag_next = 1'b1;
                        if (mode_reg == MODE_PWM)
                            wave_next = 1'b0;
                    end
                    if (counter_reg == COUNT_MAX && step_value == '0)
                    begin
                        ovf_flag_next = 1'b1;
                        if (mode_reg == MODE_PWM)
                            wave_next = 1'b1;
                    end
                    counter_next = step_value;
                end
            end
            REQ_LOAD:
            begin
                counter_next = COUNT_WIDTH'(s1_load_reg);
            end
            REQ_CLEAR:
            begin
                if (s1_mask_reg[0])
                    ovf_flag_next = 1'b0;
                if (s1_mask_reg[1])
                    cmp_flag_next = 1'b0;
            end
            default:
            begin
                // unused request code leaves the state alone
            end
        endcase
    end

    // timer state advances only when the transaction moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            counter_reg  <= '0;
            ovf_flag_reg <= 1'b0;
            cmp_flag_reg <= 1'b0;
            last_pin_reg <= 1'b0;
            wave_reg     <= 1'b0;
        end
        else if (s1_fire)
        begin
            prescale_reg <= prescale_next;
            counter_reg  <= counter_next;
            ovf_flag_reg <= ovf_flag_next;
            cmp_flag_reg <= cmp_flag_next;
            last_pin_reg <= last_pin_next;
            wave_reg     <= wave_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg  <= req_type;
            s1_pin_reg  <= ext_pin;
            s1_load_reg <= load_value;
            s1_mask_reg <= clear_mask;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_count_reg <= counter_next[7:0];
            out_ovf_reg   <= ovf_flag_next;
            out_cmp_reg   <= cmp_flag_next;
            out_irq_reg   <= (ovf_flag_next && ovf_irq_en_reg) ||
                             (cmp_flag_next && cmp_irq_en_reg);
            out_pwm_reg   <= (mode_reg == MODE_PWM) && wave_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign count         = out_count_reg;
    assign overflow_flag = out_ovf_reg;
    assign compare_flag  = out_cmp_reg;
    assign irq           = out_irq_reg;
    assign pwm_out       = out_pwm_reg;

    // input stage stalls only behind a full, blocked result stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    // a load sets the counter to the loaded value
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_req_reg == REQ_LOAD) |=>
            (counter_reg == COUNT_WIDTH'($past(s1_load_reg))))
        else $error("counter load lost");

    // the prescaler moves only on a tick
    a_prescale: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_req_reg != REQ_TICK) |=> $stable(prescale_reg))
        else $error("prescaler advanced without a tick");

    // outside fast pwm the wave output stays low
    a_pwm_low: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && mode_reg != MODE_PWM) |=> !out_pwm_reg)
        else $error("pwm output high outside pwm mode");

    // result flags mirror the timer state they were taken from
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (out_ovf_reg == ovf_flag_reg && out_cmp_reg == cmp_flag_reg))
        else $error("result flags differ from state");

endmodule

`default_nettype wire

// ===== tb/timer_counter_8bit_pwm_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for timer_counter_8bit_pwm_unit: directed table, then random phases
// keeps its own timer model and checks every result field; depends on tc8pwm_pkg and the rtl
module timer_counter_8bit_pwm_unit_test;

    import tc8pwm_pkg::*;

    // codes the package leaves out: the spare request type and the spare mode
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int PLAN_LEN        = 35;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 102;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    // one status word as the block reports it
    typedef struct packed {
        count_t cnt;
        logic   ovf;
        logic   cmpf;
        logic   irq;
        logic   pwm;
    } timer_status_t;

    localparam timer_status_t NO_STATUS = '0;

    typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

    // directed table row: either a register write or one request transaction
    typedef struct {
        row_kind_t     kind;
        cfg_idx_t      reg_idx;
        logic [7:0]    reg_val;
        logic [1:0]    req;
        logic          pin;
        logic [7:0]    load;
        logic [1:0]    mask;
        bit            typed;
        timer_status_t status;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = '0;
    logic       ext_pin = 1'b0;
    logic [7:0] load_value = '0;
    logic [1:0] clear_mask = '0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] count;
    logic       overflow_flag;
    logic       compare_flag;
    logic       irq;
    logic       pwm_out;

    // typed expectation travels with the transaction it belongs to
    bit            row_typed = 1'b0;
    timer_status_t row_status = '0;

    // shared between the request and result sides
    bit idle_off = 1'b0;
    bit hold_off_req = 1'b0;

    timer_status_t due_status[$];
    int            fault_count = 0;
    int            quiet_cycles = 0;

    // timer model: configuration
    logic [1:0] tm_mode = '0;
    logic [2:0] tm_clk_sel = '0;
    count_t     tm_compare = '0;
    logic       tm_ovf_en = 1'b0;
    logic       tm_cmp_en = 1'b0;

    // timer model: state, all zero after reset
    prescale_t  tm_prescale = '0;
    count_t     tm_count = '0;
    logic       tm_ovf = 1'b0;
    logic       tm_cmpf = 1'b0;
    logic       tm_last_pin = 1'b0;
    logic       tm_wave = 1'b0;

    plan_row_t directed_plan [PLAN_LEN];

    timer_counter_8bit_pwm_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .ext_pin       (ext_pin),
        .load_value    (load_value),
        .clear_mask    (clear_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .count         (count),
        .overflow_flag (overflow_flag),
        .compare_flag  (compare_flag),
        .irq           (irq),
        .pwm_out       (pwm_out)
    );

    always #5 clk = ~clk;

    // advance the timer model by one request and return the status it reports
    function automatic timer_status_t advance_timer(logic [1:0] req, logic pin,
                                                    count_t load, logic [1:0] mask);
        timer_status_t st;
        logic          fire;
        logic          hit;
        count_t        nxt;
        fire = 1'b0;
        if (req == REQ_TICK)
        begin
            case (tm_clk_sel)
                CS_DIV1:     fire = 1'b1;
                CS_DIV8:     fire = &tm_prescale[2:0];
                CS_DIV64:    fire = &tm_prescale[5:0];
                CS_DIV256:   fire = &tm_prescale[7:0];
                CS_DIV1024:  fire = &tm_prescale;
                CS_EXT_FALL: fire = tm_last_pin && !pin;
                CS_EXT_RISE: fire = !tm_last_pin && pin;
                default:     fire = 1'b0;
            endcase
            // prescaler free-runs on every tick, whatever the clock select
            tm_prescale = tm_prescale + 1'b1;
            tm_last_pin = pin;
            if (fire)
            begin
                hit = (tm_count == tm_compare);
                if (hit)
                begin
                    tm_cmpf = 1'b1;
                    if (tm_mode == MODE_PWM)
                        tm_wave = 1'b0;
                end
                // clear on compare only in ctc, otherwise plain increment with wrap
                nxt = (tm_mode == MODE_CTC && hit) ? '0 : tm_count + 1'b1;
                if (tm_count == COUNT_MAX && nxt == '0)
                begin
                    tm_ovf = 1'b1;
                    if (tm_mode == MODE_PWM)
                        tm_wave = 1'b1;
                end
                tm_count = nxt;
            end
        end
        else if (req == REQ_LOAD)
        begin
            tm_count = load;
        end
        else if (req == REQ_CLEAR)
        begin
            if (mask[0])
                tm_ovf = 1'b0;
            if (mask[1])
                tm_cmpf = 1'b0;
        end
        // spare request type leaves everything alone
        st.cnt  = tm_count;
        st.ovf  = tm_ovf;
        st.cmpf = tm_cmpf;
        st.irq  = (tm_ovf & tm_ovf_en) | (tm_cmpf & tm_cmp_en);
        st.pwm  = (tm_mode == MODE_PWM) ? tm_wave : 1'b0;
        return st;
    endfunction

    // drop valid, then wait until every expected status has come back
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write per cycle; caller lowers cfg_we after the last one
    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_MODE:       tm_mode    = val[1:0];
            CFG_CLOCK_SEL:  tm_clk_sel = val[2:0];
            CFG_COMPARE:    tm_compare = val;
            CFG_OVF_IRQ_EN: tm_ovf_en  = val[0];
            CFG_CMP_IRQ_EN: tm_cmp_en  = val[0];
            default: ;
        endcase
    endtask

    // offer one request transaction; returns at the edge that accepts it
    task automatic send_request(logic [1:0] req, logic pin, logic [7:0] load,
                                logic [1:0] mask, bit typed, timer_status_t st);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= req;
        ext_pin    <= pin;
        load_value <= load;
        clear_mask <= mask;
        row_typed  <= typed;
        row_status <= st;
        // inputs only move at rising edges, so ready seen at the falling edge holds
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    // scoreboard: check results, predict on accepted requests, watch for hangs
    always @(posedge clk)
    begin : scoreboard
        timer_status_t want;
        timer_status_t pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_status.size() == 0)
                begin
                    $error("status with no transaction pending: count %0h", count);
                    fault_count++;
                end
                else
                begin
                    want = due_status.pop_front();
                    if (count !== want.cnt)
                    begin
                        $error("count: expected %0h, got %0h", want.cnt, count);
                        fault_count++;
                    end
                    if (overflow_flag !== want.ovf)
                    begin
                        $error("overflow_flag: expected %0b, got %0b", want.ovf, overflow_flag);
                        fault_count++;
                    end
                    if (compare_flag !== want.cmpf)
                    begin
                        $error("compare_flag: expected %0b, got %0b", want.cmpf, compare_flag);
                        fault_count++;
                    end
                    if (irq !== want.irq)
                    begin
                        $error("irq: expected %0b, got %0b", want.irq, irq);
                        fault_count++;
                    end
                    if (pwm_out !== want.pwm)
                    begin
                        $error("pwm_out: expected %0b, got %0b", want.pwm, pwm_out);
                        fault_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                // model always steps; a typed row overrides what gets compared
                pred = advance_timer(req_type, ext_pin, load_value, clear_mask);
                due_status.push_back(row_typed ? row_status : pred);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("timer_counter_8bit_pwm_unit_test: done, errors");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : status_sink
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                // long stall so the block fills and pushes back on requests
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = idle_off ? 0 : $urandom_range(0, 18);
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    // request side: directed table, then random phases
    initial
    begin : request_source
        bit         in_writes;
        logic [1:0] ph_mode;
        logic [2:0] ph_clk_sel;
        count_t     ph_compare;
        logic [1:0] req;
        logic [7:0] load;
        int         pick;

        // reset state checks, wrap and match at the extremes, flag clears,
        // ctc wrap on a match at max, pwm set and clear, spare mode and request,
        // both external edges
        directed_plan = '{
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b1,
              '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b1,
              '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_LOAD, 1'b0, 8'hff, 2'b00, 1'b1,
              '{8'hff, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_WRITE, CFG_CLOCK_SEL, 8'(CS_DIV1), REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_OVF_IRQ_EN, 8'h01, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_CMP_IRQ_EN, 8'h01, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_COMPARE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b1,
              '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b1,
              '{8'h01, 1'b1, 1'b1, 1'b1, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_CLEAR, 1'b0, 8'h00, 2'b01, 1'b1,
              '{8'h01, 1'b0, 1'b1, 1'b1, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_CLEAR, 1'b0, 8'h00, 2'b10, 1'b1,
              '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_UNUSED, 1'b1, 8'haa, 2'b11, 1'b1,
              '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_CLEAR, 1'b1, 8'h55, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_MODE, 8'(MODE_CTC), REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_COMPARE, 8'hff, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_LOAD, 1'b0, 8'hfe, 2'b00, 1'b1,
              '{8'hfe, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b1,
              '{8'hff, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b1,
              '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_CLEAR, 1'b0, 8'h00, 2'b11, 1'b1,
              '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_WRITE, CFG_MODE, 8'(MODE_PWM), REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_COMPARE, 8'h01, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b1,
              '{8'h01, 1'b0, 1'b0, 1'b0, 1'b0}},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_LOAD, 1'b0, 8'hff, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_MODE, 8'(MODE_UNUSED), REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_CLOCK_SEL, 8'(CS_EXT_FALL), REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_CLOCK_SEL, 8'(CS_EXT_RISE), REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b1, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_WRITE, CFG_CLOCK_SEL, 8'(CS_DIV8), REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS},
            '{ROW_ITEM,  CFG_MODE, 8'h00, REQ_TICK, 1'b0, 8'h00, 2'b00, 1'b0,
              NO_STATUS}
        };

        // reset held low from the start, released once
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the table; a run of writes waits for the block to go idle first
        in_writes = 1'b0;
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (directed_plan[i].kind == ROW_WRITE)
            begin
                if (!in_writes)
                begin
                    wait_for_quiet();
                    in_writes = 1'b1;
                end
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end
            else
            begin
                if (in_writes)
                begin
                    @(posedge clk);
                    cfg_we <= 1'b0;
                    in_writes = 1'b0;
                end
                send_request(directed_plan[i].req, directed_plan[i].pin,
                             directed_plan[i].load, directed_plan[i].mask,
                             directed_plan[i].typed, directed_plan[i].status);
            end
        end

        // random phases: new settings each phase, mostly ticks with loads near
        // the interesting counter values, some clears and spare requests
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_quiet();
            if (phase == 0)
            begin
                ph_mode    = MODE_PWM;
                ph_clk_sel = CS_DIV1;
                ph_compare = 8'h80;
            end
            else if (phase == 1)
            begin
                ph_mode    = MODE_CTC;
                ph_clk_sel = CS_DIV1;
                ph_compare = 8'h00;
            end
            else
            begin
                ph_mode    = ($urandom_range(0, 9) == 0) ? MODE_UNUSED
                                                          : 2'($urandom_range(0, 2));
                ph_clk_sel = ($urandom_range(0, 9) == 0) ? CS_STOP
                                                          : 3'($urandom_range(1, 7));
                pick = $urandom_range(0, 3);
                ph_compare = (pick == 0) ? 8'h00 :
                             (pick == 1) ? COUNT_MAX : 8'($urandom);
            end
            write_reg(CFG_MODE, 8'(ph_mode));
            write_reg(CFG_CLOCK_SEL, 8'(ph_clk_sel));
            write_reg(CFG_COMPARE, ph_compare);
            write_reg(CFG_OVF_IRQ_EN, 8'($urandom_range(0, 1)));
            write_reg(CFG_CMP_IRQ_EN, 8'($urandom_range(0, 1)));
            @(posedge clk);
            cfg_we <= 1'b0;

            // some phases run back to back; the hold phase floods the input
            idle_off = (phase % 4 == 3) || (phase == HOLD_PHASE);
            if (phase == HOLD_PHASE)
                hold_off_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                req  = (pick < 78) ? REQ_TICK :
                       (pick < 88) ? REQ_LOAD :
                       (pick < 96) ? REQ_CLEAR : REQ_UNUSED;
                pick = $urandom_range(0, 2);
                load = (pick == 0) ? ph_compare - 8'($urandom_range(0, 3)) :
                       (pick == 1) ? COUNT_MAX - 8'($urandom_range(0, 3)) : 8'($urandom);
                send_request(req, 1'($urandom_range(0, 1)), load,
                             2'($urandom_range(0, 3)), 1'b0, NO_STATUS);
            end
            idle_off = 1'b0;
        end

        // drain, then report
        wait_for_quiet();
        if (due_status.size() != 0)
        begin
            $error("%0d status words never arrived", due_status.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("timer_counter_8bit_pwm_unit_test: done, clean");
        else
            $display("timer_counter_8bit_pwm_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tc8pwm_pkg.sv
hw/rtl/timer_counter_8bit_pwm_unit.sv
tb/timer_counter_8bit_pwm_unit_test.sv
